// File: rtl/rqq_pkg.sv
package rqq_pkg;

   typedef enum logic [2:0] {
      OP_INSERT  = 3'd0,
      OP_REMOVE  = 3'd1,
      OP_HEAD    = 3'd2,
      OP_TAIL    = 3'd3,
      OP_LOOKUP  = 3'd4,
      OP_QUANTUM = 3'd5,
      OP_NONE6   = 3'd6,
      OP_NONE7   = 3'd7
   } op_type;

   typedef enum logic [1:0] {
      ST_OK       = 2'd0,
      ST_NOTFOUND = 2'd1,
      ST_FULL     = 2'd2,
      ST_ZERODIV  = 2'd3
   } status_type;

   typedef struct packed {
      logic [2:0]  operation;
      logic [15:0] process_id;
      logic [2:0]  group;
   } req_type;

   typedef struct packed {
      logic [1:0]  status;
      logic [15:0] entry_id;
      logic [2:0]  entry_group;
      logic [15:0] slice;
      logic [4:0]  occupancy;
   } rsp_type;

   // The divisor is at most four groups times the entries of one group.
   localparam int DIVISOR_W = 10;

   // Command broadcast to every cell.
   typedef enum logic [3:0] {
      CC_HOLD  = 4'b0001,
      CC_LEFT  = 4'b0010,
      CC_RIGHT = 4'b0100,
      CC_WRITE = 4'b1000
   } cell_cmd_type;

   typedef struct packed {
      cell_cmd_type cmd;
      logic [15:0]  wr_id;
      logic [1:0]   wr_grp;
   } cell_ctl_type;

endpackage

// File: rtl/rqq_if.sv
interface rqq_req_if;
   import rqq_pkg::*;
   logic    valid;
   logic    ready;
   req_type payload;
   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

interface rqq_rsp_if;
   import rqq_pkg::*;
   logic    valid;
   logic    ready;
   rsp_type payload;
   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

// File: rtl/ready_queue_with_quantum.sv
// Ordered ready queue of process ids with a time-slice query.
// The req channel carries one item per operation: insert, remove, move to head,
// move to tail, lookup or quantum. The rsp channel returns exactly one item
// for each request, in order. The csr port writes the total quantum whenever
// csr_write is high; write it only while no item is in flight.
// Entries sit in a row of cells. A search walks the row one cell per cycle
// and stops at the match, or reports a miss after the last position. A
// remove shifts every cell from the match to the end left together; a move
// shifts the span and then writes the entry at the head or tail. An insert
// writes the new entry behind the last one. A quantum query scans every
// entry and, unless the divisor is zero, then runs a 16-step restoring divider.
// One item is handled at a time; req_ready is high only while idle, and it
// returns in the cycle after the result is taken.
// The result waits in an output register until taken; a stalled receiver
// holds the block, with queue contents unchanged. Reset empties the queue,
// clears the quantum and drops rsp_valid.
module ready_queue_with_quantum #(
   parameter int DEPTH = 16
) (
   input  logic       clock,
   input  logic       reset,
   rqq_req_if.sink    req,
   rqq_rsp_if.source  rsp,
   input  logic       csr_write,
   input  logic [15:0] csr_wdata
);
   import rqq_pkg::*;

   localparam int IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   typedef enum logic [6:0] {
      S_IDLE  = 7'b0000001,
      S_SCAN  = 7'b0000010,
      S_SHIFT = 7'b0000100,
      S_PUT   = 7'b0001000,
      S_DIV   = 7'b0010000,
      S_WAIT  = 7'b0100000,
      S_OUT   = 7'b1000000
   } state_type;

   state_type   state_ff, state_in;
   logic [15:0] quantum_ff;
   logic [CW-1:0] count_ff, count_in;
   logic [CW-1:0] pos_ff, pos_in;
   logic [CW-1:0] lo_ff, lo_in, hi_ff, hi_in;
   logic [2:0]  op_ff, op_in;
   logic [15:0] pid_ff, pid_in;
   logic [2:0]  grp_ff, grp_in;
   logic [15:0] fid_ff, fid_in;
   logic [1:0]  fgrp_ff, fgrp_in;
   logic [3:0]  present_ff, present_in;
   logic [CW-1:0] members_ff, members_in;
   rsp_type     out_ff, out_in;
   logic        valid_ff, valid_in;
   logic        div_start;
   logic        div_done;
   logic [15:0] div_q;
   logic [DIVISOR_W-1:0] div_d;
   logic [2:0]  ngroups;
   logic [CW+2:0] prod;
   cell_ctl_type ctl;
   logic [DEPTH-1:0] shift_en, write_en;
   logic [15:0] ids [DEPTH];
   logic [1:0]  grps [DEPTH];
   logic [15:0] cur_id;
   logic [1:0]  cur_grp;
   logic [CW-1:0] last;

   genvar g;
   generate
      for (g = 0; g < DEPTH; g++) begin : gen_cell
         logic [15:0] lid, rid;
         logic [1:0]  lg, rg;
         if (g == 0) begin : gen_l0
            assign lid = '0;
            assign lg  = '0;
         end else begin : gen_l
            assign lid = ids[g-1];
            assign lg  = grps[g-1];
         end
         if (g == DEPTH - 1) begin : gen_rn
            assign rid = '0;
            assign rg  = '0;
         end else begin : gen_r
            assign rid = ids[g+1];
            assign rg  = grps[g+1];
         end
         assign shift_en[g] = (CW'(g) >= lo_ff) && (CW'(g) <= hi_ff);
         assign write_en[g] = (state_ff == S_PUT) && (CW'(g) == pos_ff);
         rqq_cell u_cell (
            .clock     (clock),
            .ctl       (ctl),
            .shift_en  (shift_en[g] && state_ff == S_SHIFT),
            .write_en  (write_en[g]),
            .left_id   (lid),
            .left_grp  (lg),
            .right_id  (rid),
            .right_grp (rg),
            .id        (ids[g]),
            .grp       (grps[g])
         );
      end
   endgenerate

   assign cur_id  = ids[pos_ff[IW-1:0]];
   assign cur_grp = grps[pos_ff[IW-1:0]];
   assign last    = count_ff - CW'(1);

   always_comb begin
      ngroups = 3'(present_ff[0]) + 3'(present_ff[1]) + 3'(present_ff[2])
              + 3'(present_ff[3]);
      prod    = (CW+3)'(ngroups) * (CW+3)'(members_ff);
   end

   rqq_divider u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (quantum_ff),
      .divisor  (div_d),
      .done     (div_done),
      .quotient (div_q)
   );

   always_comb begin
      state_in   = state_ff;
      count_in   = count_ff;
      pos_in     = pos_ff;
      lo_in      = lo_ff;
      hi_in      = hi_ff;
      op_in      = op_ff;
      pid_in     = pid_ff;
      grp_in     = grp_ff;
      fid_in     = fid_ff;
      fgrp_in    = fgrp_ff;
      present_in = present_ff;
      members_in = members_ff;
      out_in     = out_ff;
      valid_in   = valid_ff;
      div_start  = 1'b0;
      div_d      = DIVISOR_W'(prod);
      ctl.cmd    = CC_HOLD;
      ctl.wr_id  = fid_ff;
      ctl.wr_grp = fgrp_ff;
      if (op_ff == OP_HEAD) ctl.cmd = CC_RIGHT;
      else ctl.cmd = CC_LEFT;
      if (state_ff == S_PUT) ctl.cmd = CC_WRITE;
      if (state_ff != S_SHIFT && state_ff != S_PUT) ctl.cmd = CC_HOLD;

      unique case (state_ff)
         S_IDLE: begin
            if (req.valid) begin
               op_in      = req.payload.operation;
               pid_in     = req.payload.process_id;
               grp_in     = req.payload.group;
               pos_in     = '0;
               present_in = '0;
               members_in = '0;
               out_in     = '0;
               unique case (op_type'(req.payload.operation))
                  OP_INSERT: begin
                     if (count_ff >= CW'(DEPTH)) begin
                        out_in.status = ST_FULL;
                        state_in = S_OUT;
                     end else begin
                        pos_in  = count_ff;
                        fid_in  = req.payload.process_id;
                        fgrp_in = (req.payload.group >= 3'd1 && req.payload.group <= 3'd3)
                                ? 2'(req.payload.group - 3'd1) : 2'd3;
                        count_in = count_ff + CW'(1);
                        state_in = S_PUT;
                     end
                  end
                  OP_REMOVE, OP_HEAD, OP_TAIL, OP_LOOKUP, OP_QUANTUM: begin
                     if (count_ff == '0) begin
                        out_in.status = ST_NOTFOUND;
                        state_in = S_OUT;
                     end else begin
                        state_in = S_SCAN;
                     end
                  end
                  default: state_in = S_OUT;
               endcase
            end
         end
         S_SCAN: begin
            if (op_ff == OP_QUANTUM) begin
               present_in[cur_grp] = 1'b1;
               if ({1'b0, cur_grp} + 3'd1 == grp_ff) members_in = members_ff + CW'(1);
               if (pos_ff == last) state_in = S_DIV;
               else pos_in = pos_ff + CW'(1);
            end else if (cur_id == pid_ff) begin
               fid_in  = cur_id;
               fgrp_in = cur_grp;
               out_in.entry_id    = cur_id;
               out_in.entry_group = {1'b0, cur_grp} + 3'd1;
               unique case (op_type'(op_ff))
                  OP_REMOVE: begin
                     lo_in = pos_ff;
                     hi_in = last;
                     count_in = last;
                     state_in = S_SHIFT;
                  end
                  OP_HEAD: begin
                     lo_in = CW'(1);
                     hi_in = pos_ff;
                     pos_in = '0;
                     state_in = S_SHIFT;
                  end
                  OP_TAIL: begin
                     lo_in = pos_ff;
                     hi_in = last - CW'(1);
                     pos_in = last;
                     state_in = S_SHIFT;
                  end
                  default: state_in = S_OUT;
               endcase
            end else if (pos_ff == last) begin
               out_in.status = ST_NOTFOUND;
               state_in = S_OUT;
            end else begin
               pos_in = pos_ff + CW'(1);
            end
         end
         S_SHIFT: begin
            lo_in = CW'(DEPTH);
            hi_in = '0;
            if (op_ff == OP_REMOVE) state_in = S_OUT;
            else state_in = S_PUT;
         end
         S_PUT: begin
            out_in.occupancy = 5'(count_ff);
            state_in = S_OUT;
         end
         S_DIV: begin
            if (prod == '0) begin
               out_in.status = ST_ZERODIV;
               state_in = S_OUT;
            end else begin
               div_start = 1'b1;
               state_in = S_WAIT;
            end
         end
         S_WAIT: begin
            if (div_done) begin
               out_in.slice = div_q;
               state_in = S_OUT;
            end
         end
         S_OUT: begin
            if (!valid_ff) begin
               out_in.occupancy = 5'(count_ff);
               valid_in = 1'b1;
            end else if (rsp.ready) begin
               valid_in = 1'b0;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= S_IDLE;
         count_ff   <= '0;
         valid_ff   <= 1'b0;
         quantum_ff <= '0;
         lo_ff      <= CW'(DEPTH);
         hi_ff      <= '0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         valid_ff <= valid_in;
         lo_ff    <= lo_in;
         hi_ff    <= hi_in;
         if (csr_write) quantum_ff <= csr_wdata;
      end
      pos_ff     <= pos_in;
      op_ff      <= op_in;
      pid_ff     <= pid_in;
      grp_ff     <= grp_in;
      fid_ff     <= fid_in;
      fgrp_ff    <= fgrp_in;
      present_ff <= present_in;
      members_ff <= members_in;
      out_ff     <= out_in;
   end

   assign req.ready   = (state_ff == S_IDLE);
   assign rsp.valid   = valid_ff;
   assign rsp.payload = out_ff;
endmodule

// File: rtl/rqq_cell.sv
module rqq_cell (
   input  logic                  clock,
   input  rqq_pkg::cell_ctl_type ctl,
   input  logic                  shift_en,
   input  logic                  write_en,
   input  logic [15:0]           left_id,
   input  logic [1:0]            left_grp,
   input  logic [15:0]           right_id,
   input  logic [1:0]            right_grp,
   output logic [15:0]           id,
   output logic [1:0]            grp
);
   import rqq_pkg::*;

   logic [15:0] id_ff, id_in;
   logic [1:0]  grp_ff, grp_in;

   always_comb begin
      id_in  = id_ff;
      grp_in = grp_ff;
      if (write_en) begin
         id_in  = ctl.wr_id;
         grp_in = ctl.wr_grp;
      end else if (shift_en) begin
         unique case (ctl.cmd)
            CC_LEFT: begin
               id_in  = right_id;
               grp_in = right_grp;
            end
            CC_RIGHT: begin
               id_in  = left_id;
               grp_in = left_grp;
            end
            default: begin
               id_in  = id_ff;
               grp_in = grp_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      id_ff  <= id_in;
      grp_ff <= grp_in;
   end

   assign id  = id_ff;
   assign grp = grp_ff;
endmodule

// File: rtl/rqq_divider.sv
module rqq_divider (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            start,
   input  logic [15:0]                     dividend,
   input  logic [rqq_pkg::DIVISOR_W-1:0]   divisor,
   output logic                            done,
   output logic [15:0]                     quotient
);
   import rqq_pkg::*;

   logic [15:0]          quo_ff, quo_in;
   logic [DIVISOR_W-1:0] rem_ff, rem_in;
   logic [DIVISOR_W-1:0] div_ff, div_in;
   logic [4:0]           cnt_ff, cnt_in;
   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   logic [DIVISOR_W:0]   trial;

   always_comb begin
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      div_in  = div_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      trial   = {rem_ff, quo_ff[15]};
      if (start) begin
         quo_in  = dividend;
         rem_in  = '0;
         div_in  = divisor;
         cnt_in  = 5'd16;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (trial >= {1'b0, div_ff}) begin
            rem_in = DIVISOR_W'(trial - {1'b0, div_ff});
            quo_in = {quo_ff[14:0], 1'b1};
         end else begin
            rem_in = trial[DIVISOR_W-1:0];
            quo_in = {quo_ff[14:0], 1'b0};
         end
         cnt_in = cnt_ff - 5'd1;
         if (cnt_ff == 5'd1) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      div_ff <= div_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff;
endmodule

// File: dv/tb_ready_queue_with_quantum.sv
`timescale 1ns / 100ps

module tb_ready_queue_with_quantum;
   import rqq_pkg::*;

   localparam int DEPTH = 16;
   localparam int CYCLE_LIMIT = 400000;

   logic        clock;
   logic        reset;
   logic        csr_write;
   logic [15:0] csr_wdata;

   rqq_req_if req_ch ();
   rqq_rsp_if rsp_ch ();

   ready_queue_with_quantum #(.DEPTH(DEPTH)) dut (
      .clock     (clock),
      .reset     (reset),
      .req       (req_ch.sink),
      .rsp       (rsp_ch.source),
      .csr_write (csr_write),
      .csr_wdata (csr_wdata)
   );

   // Model of the queue contents, head at index 0.
   logic [15:0] model_ids[$];
   logic [1:0]  model_grps[$];
   logic [15:0] model_quantum;

   req_type pending_items[$];
   rsp_type expected_rsps[$];

   int  send_idle_pct;
   int  recv_idle_pct;
   int  hold_off_cycles;
   int  error_count;
   int  rsp_count;
   int  cycle_count;
   int  ok_count;
   int  full_count;
   int  miss_count;
   int  zdiv_count;
   bit  driver_paused;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   task automatic report_mismatch(input string what, input logic [15:0] got,
                                  input logic [15:0] want);
      $display("mismatch at response %0d: %s got %0h expected %0h",
               rsp_count, what, got, want);
      error_count++;
   endtask

   function automatic int find_entry(input logic [15:0] id);
      for (int i = 0; i < model_ids.size(); i++) begin
         if (model_ids[i] == id) begin
            return i;
         end
      end
      return -1;
   endfunction

   // Applies one operation to the queue model and returns its response.
   function automatic rsp_type schedule_op(input req_type item);
      rsp_type     r;
      int          pos;
      logic [15:0] sid;
      logic [1:0]  sg;
      bit [3:0]    present;
      int          groups;
      int          members;
      r = '0;
      case (op_type'(item.operation))
         OP_INSERT: begin
            if (model_ids.size() >= DEPTH) begin
               r.status = ST_FULL;
            end else begin
               model_ids.push_back(item.process_id);
               model_grps.push_back((item.group >= 1 && item.group <= 3) ?
                                    2'(item.group - 1) : 2'd3);
            end
         end
         OP_REMOVE, OP_HEAD, OP_TAIL, OP_LOOKUP: begin
            pos = find_entry(item.process_id);
            if (pos < 0) begin
               r.status = ST_NOTFOUND;
            end else begin
               sid = model_ids[pos];
               sg = model_grps[pos];
               r.entry_id = sid;
               r.entry_group = 3'(sg) + 3'd1;
               if (op_type'(item.operation) != OP_LOOKUP) begin
                  model_ids.delete(pos);
                  model_grps.delete(pos);
                  if (op_type'(item.operation) == OP_HEAD) begin
                     model_ids.push_front(sid);
                     model_grps.push_front(sg);
                  end else if (op_type'(item.operation) == OP_TAIL) begin
                     model_ids.push_back(sid);
                     model_grps.push_back(sg);
                  end
               end
            end
         end
         OP_QUANTUM: begin
            if (model_ids.size() == 0) begin
               r.status = ST_NOTFOUND;
            end else begin
               present = '0;
               members = 0;
               foreach (model_grps[i]) begin
                  present[model_grps[i]] = 1'b1;
                  if (int'(model_grps[i]) + 1 == int'(item.group)) begin
                     members++;
                  end
               end
               groups = $countones(present);
               if (groups * members == 0) begin
                  r.status = ST_ZERODIV;
               end else begin
                  r.slice = 16'(int'(model_quantum) / (groups * members));
               end
            end
         end
         default: ;
      endcase
      r.occupancy = 5'(model_ids.size());
      return r;
   endfunction

   // Driver: offers the pending items, idling at random.
   always @(posedge clock) begin
      if (reset) begin
         req_ch.valid <= 1'b0;
         req_ch.payload <= '0;
      end else begin
         if (req_ch.valid && req_ch.ready) begin
            expected_rsps.push_back(schedule_op(req_ch.payload));
            void'(pending_items.pop_front());
         end
         if ((!req_ch.valid || req_ch.ready) && !driver_paused) begin
            if (pending_items.size() > (req_ch.valid && req_ch.ready ? 0 : 0) &&
                pending_items.size() > 0 &&
                $urandom_range(99) >= send_idle_pct) begin
               req_ch.valid <= 1'b1;
               req_ch.payload <= pending_items[0];
            end else begin
               req_ch.valid <= 1'b0;
            end
         end else if (driver_paused && (!req_ch.valid || req_ch.ready)) begin
            req_ch.valid <= 1'b0;
         end
      end
   end

   // Monitor: takes responses, stalling at random or for a long hold-off.
   always @(posedge clock) begin
      if (reset) begin
         rsp_ch.ready <= 1'b0;
      end else begin
         if (rsp_ch.valid && rsp_ch.ready) begin
            if (expected_rsps.size() == 0) begin
               report_mismatch("unexpected response", 16'd0, 16'd0);
            end else begin
               rsp_type want;
               want = expected_rsps.pop_front();
               if (rsp_ch.payload.status != want.status)
                  report_mismatch("status", 16'(rsp_ch.payload.status), 16'(want.status));
               if (rsp_ch.payload.entry_id != want.entry_id)
                  report_mismatch("entry_id", rsp_ch.payload.entry_id, want.entry_id);
               if (rsp_ch.payload.entry_group != want.entry_group)
                  report_mismatch("entry_group", 16'(rsp_ch.payload.entry_group),
                                  16'(want.entry_group));
               if (rsp_ch.payload.slice != want.slice)
                  report_mismatch("slice", rsp_ch.payload.slice, want.slice);
               if (rsp_ch.payload.occupancy != want.occupancy)
                  report_mismatch("occupancy", 16'(rsp_ch.payload.occupancy),
                                  16'(want.occupancy));
               case (status_type'(want.status))
                  ST_OK:       ok_count++;
                  ST_FULL:     full_count++;
                  ST_NOTFOUND: miss_count++;
                  default:     zdiv_count++;
               endcase
            end
            rsp_count++;
         end
         if (hold_off_cycles > 0) begin
            hold_off_cycles <= hold_off_cycles - 1;
            rsp_ch.ready <= 1'b0;
         end else begin
            rsp_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycle_count);
         $display("tb_ready_queue_with_quantum: FAIL");
         $finish;
      end
   end

   function automatic logic [15:0] pick_id();
      if (model_ids.size() > 0 && $urandom_range(3) != 0) begin
         return model_ids[$urandom_range(model_ids.size() - 1)];
      end
      return 16'($urandom_range(15));
   endfunction

   function automatic req_type make_item(input op_type op, input logic [15:0] id,
                                         input logic [2:0] grp);
      req_type item;
      item.operation = op;
      item.process_id = id;
      item.group = grp;
      return item;
   endfunction

   task automatic wait_drained();
      while (pending_items.size() > 0 || req_ch.valid || expected_rsps.size() > 0) begin
         @(posedge clock);
      end
      repeat (60) @(posedge clock);
   endtask

   task automatic write_quantum(input logic [15:0] value);
      csr_write <= 1'b1;
      csr_wdata <= value;
      @(posedge clock);
      csr_write <= 1'b0;
      model_quantum = value;
   endtask

   // Fills random items; the id pool stays small so that matches are common.
   task automatic queue_random(input int count);
      int      roll;
      req_type item;
      for (int n = 0; n < count; n++) begin
         roll = $urandom_range(99);
         if (roll < 30) begin
            item = make_item(OP_INSERT, 16'($urandom_range(15)),
                             3'($urandom_range(1, 4)));
            if ($urandom_range(9) == 0) item.group = 3'($urandom);
            if ($urandom_range(9) == 0) item.process_id = 16'($urandom);
         end else if (roll < 94) begin
            item = make_item(op_type'($urandom_range(1, 5)), 16'($urandom_range(15)),
                             3'($urandom_range(1, 4)));
            if ($urandom_range(9) == 0) item.process_id = 16'($urandom);
            if ($urandom_range(9) == 0) item.group = 3'($urandom);
         end else begin
            item = make_item(op_type'($urandom_range(6, 7)), 16'($urandom),
                             3'($urandom));
         end
         pending_items.push_back(item);
      end
   endtask

   initial begin
      reset = 1'b1;
      csr_write = 1'b0;
      csr_wdata = '0;
      req_ch.valid = 1'b0;
      req_ch.payload = '0;
      rsp_ch.ready = 1'b0;
      send_idle_pct = 36;
      recv_idle_pct = 46;
      hold_off_cycles = 0;
      error_count = 0;
      rsp_count = 0;
      cycle_count = 0;
      driver_paused = 1'b0;
      model_quantum = '0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: empty-queue cases with the reset quantum, then fill past full.
      pending_items.push_back(make_item(OP_QUANTUM, 16'd0, 3'd1));
      pending_items.push_back(make_item(OP_REMOVE, 16'hFFFF, 3'd1));
      pending_items.push_back(make_item(OP_LOOKUP, 16'd0, 3'd1));
      pending_items.push_back(make_item(OP_INSERT, 16'hFFFF, 3'd1));
      pending_items.push_back(make_item(OP_QUANTUM, 16'd0, 3'd1));
      wait_drained();
      write_quantum(16'hFFFF);
      for (int i = 0; i < 16; i++) begin
         pending_items.push_back(make_item(OP_INSERT, 16'(i % 7), 3'(i % 8)));
      end
      pending_items.push_back(make_item(OP_INSERT, 16'h1234, 3'd2));
      pending_items.push_back(make_item(OP_QUANTUM, 16'd0, 3'd4));
      pending_items.push_back(make_item(OP_QUANTUM, 16'd0, 3'd0));
      pending_items.push_back(make_item(OP_QUANTUM, 16'd0, 3'd7));
      pending_items.push_back(make_item(OP_HEAD, 16'd3, 3'd0));
      pending_items.push_back(make_item(OP_TAIL, 16'd3, 3'd0));
      pending_items.push_back(make_item(OP_TAIL, 16'd0, 3'd0));
      pending_items.push_back(make_item(OP_REMOVE, 16'd5, 3'd0));
      pending_items.push_back(make_item(OP_NONE6, 16'hFFFF, 3'd7));
      pending_items.push_back(make_item(OP_NONE7, 16'hAAAA, 3'd5));
      wait_drained();

      write_quantum(16'd0);
      queue_random(120);
      wait_drained();
      write_quantum(16'($urandom));
      queue_random(110);
      // Long receiver stall while items keep coming.
      hold_off_cycles = 600;
      queue_random(60);
      wait_drained();

      send_idle_pct = 46;
      recv_idle_pct = 36;
      write_quantum(16'd1);
      queue_random(130);
      // Sender pauses until every outstanding response has arrived.
      driver_paused = 1'b1;
      while (req_ch.valid || expected_rsps.size() > 0) @(posedge clock);
      driver_paused = 1'b0;
      queue_random(40);
      wait_drained();

      send_idle_pct = 0;
      recv_idle_pct = 0;
      write_quantum(16'd9973);
      queue_random(120);
      wait_drained();
      write_quantum(16'hFFFF);
      queue_random(100);
      wait_drained();

      $display("covered %0d responses: %0d ok, %0d full, %0d not found, %0d zero divisor",
               rsp_count, ok_count, full_count, miss_count, zdiv_count);
      $display("quantum settings included zero, one and the maximum, with stalls on both sides");
      if (error_count == 0) begin
         $display("tb_ready_queue_with_quantum: PASS");
      end else begin
         $display("tb_ready_queue_with_quantum: FAIL");
      end
      $finish;
   end

endmodule

// File: sim.f
rtl/rqq_pkg.sv
rtl/rqq_if.sv
rtl/rqq_cell.sv
rtl/rqq_divider.sv
rtl/ready_queue_with_quantum.sv
dv/tb_ready_queue_with_quantum.sv
